FILE: rtl/nlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared sizes, register indexes and interface structs of the local threshold
// block.
// ----------------------------------------------------------------------------
package nlt_pkg;

    // frame and window limits
    localparam int MAX_RADIUS  = 40;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;

    // field widths fixed by the interface
    localparam int RADCFG_W = 6;
    localparam int K_W      = 9;
    localparam int DIMCFG_W = 12;
    localparam int CFG_W    = 12;
    localparam int COORD_W  = 11;
    localparam int PIX_W    = 8;

    // internal widths
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DLY_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int WIN_W  = $clog2(2 * MAX_RADIUS + 2);
    localparam int CNT_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int SQ_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 65025 + 1);

    // register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_K      = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    // input kinds
    localparam logic KIND_PIXEL = 1'b0;

    // effective configuration seen by both parts
    typedef struct packed {
        logic [RAD_W-1:0]    radius;
        logic [WD_W-1:0]     width;
        logic [HT_W-1:0]     height;
        logic signed [K_W-1:0] k;
        logic [DLY_W-1:0]    delay;
        logic [POS_W-1:0]    total;
    } t_cfg;

    // one result job
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_job;

    // line store write
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_wr;

endpackage

FILE: rtl/nlt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_front
// Accepts words, holds configuration and raster counters, writes the line
// store and issues a job whenever a result falls due.
// ----------------------------------------------------------------------------
module nlt_front
    import nlt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_s_tvalid,
    input  logic                i_s_tuser,
    input  logic [PIX_W-1:0]    i_s_tdata,
    output logic                o_s_tready,
    input  logic                i_q_empty,
    input  logic                i_back_busy,
    output logic                o_push,
    output t_job                o_job,
    output t_wr                 o_wr,
    output t_cfg                o_cfg
);

    logic [RADCFG_W-1:0]     r_radius;
    logic signed [K_W-1:0]   r_k;
    logic [DIMCFG_W-1:0]     r_width;
    logic [DIMCFG_W-1:0]     r_height;
    t_cfg                    r_cfg;
    t_cfg                    n_cfg;
    logic                    r_cfg_stale;

    logic [POS_W-1:0]  r_in_pos;
    logic [ADDR_W-1:0] r_in_addr;
    logic [POS_W-1:0]  r_out_pos;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [ADDR_W-1:0] r_out_addr;

    logic              acc;
    logic              wr_en;
    logic [POS_W-1:0]  n_in_pos;
    logic              due;
    logic              wrap;

    // effective register values and derived sizes
    always_comb begin
        n_cfg.radius = (r_radius == '0) ? RAD_W'(1) :
                       (32'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_radius);
        n_cfg.width  = (r_width == '0) ? WD_W'(1) :
                       (32'(r_width) > MAX_WIDTH) ? WD_W'(MAX_WIDTH) : WD_W'(r_width);
        n_cfg.height = (r_height == '0) ? HT_W'(1) :
                       (32'(r_height) > MAX_HEIGHT) ? HT_W'(MAX_HEIGHT) : HT_W'(r_height);
        n_cfg.k      = r_k;
        n_cfg.delay  = DLY_W'(n_cfg.radius * n_cfg.width) + DLY_W'(n_cfg.radius);
        n_cfg.total  = POS_W'(n_cfg.width * n_cfg.height);
    end

    // one item at a time: the store must not move while a window is read;
    // hold off while the derived configuration catches up
    assign o_s_tready = i_q_empty && !i_back_busy && !r_cfg_stale;
    assign acc        = i_s_tvalid && o_s_tready;

    // classify the word
    always_comb begin
        wr_en    = (i_s_tuser == KIND_PIXEL) && (r_in_pos < r_cfg.total);
        n_in_pos = r_in_pos + POS_W'(wr_en);
        due      = (r_out_pos < r_cfg.total) &&
                   ((n_in_pos == r_cfg.total) ||
                    ((n_in_pos - r_out_pos) > POS_W'(r_cfg.delay)));
        wrap     = (r_out_pos + POS_W'(1)) == r_cfg.total;
    end

    assign o_push    = acc && due;
    assign o_job.row  = r_out_row;
    assign o_job.col  = r_out_col;
    assign o_job.addr = r_out_addr;
    assign o_job.last = wrap;
    assign o_wr.en   = acc && wr_en;
    assign o_wr.addr = r_in_addr;
    assign o_wr.data = i_s_tdata;
    assign o_cfg     = r_cfg;

    // derived configuration
    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // derived configuration is registered, so it trails reset and register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_stale <= 1'b1;
        end else begin
            r_cfg_stale <= i_cfg_we;
        end
    end

    // registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADCFG_W'(40);
            r_k        <= -K_W'(51);
            r_width    <= DIMCFG_W'(640);
            r_height   <= DIMCFG_W'(480);
            r_in_pos   <= '0;
            r_in_addr  <= '0;
            r_out_pos  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_addr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS: r_radius <= i_cfg_data[RADCFG_W-1:0];
                REG_K:      r_k      <= i_cfg_data[K_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data[DIMCFG_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[DIMCFG_W-1:0];
                default: begin
                end
            endcase
            r_in_pos   <= '0;
            r_in_addr  <= '0;
            r_out_pos  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_addr <= '0;
        end else if (acc) begin
            if (due && wrap) begin
                // last result of the frame: both counts restart
                r_in_pos   <= '0;
                r_in_addr  <= '0;
                r_out_pos  <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_addr <= '0;
            end else begin
                if (wr_en) begin
                    r_in_pos  <= n_in_pos;
                    r_in_addr <= (32'(r_in_addr) == STORE_DEPTH - 1) ? '0 :
                                 r_in_addr + 1'b1;
                end
                if (due) begin
                    r_out_pos  <= r_out_pos + 1'b1;
                    r_out_addr <= (32'(r_out_addr) == STORE_DEPTH - 1) ? '0 :
                                  r_out_addr + 1'b1;
                    if (32'(r_out_col) == 32'(r_cfg.width) - 1) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/nlt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_queue
// Two-entry job queue between the front and the window engine.
// ----------------------------------------------------------------------------
module nlt_queue
    import nlt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && r_cnt != 2'd2) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && r_cnt != 2'd2) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push && r_cnt != 2'd2) - 2'(i_pop && o_valid);
        end
    end

endmodule

FILE: rtl/nlt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_back
// Window engine: holds the line store, sums one clipped window a tap per
// cycle, runs the threshold test and holds the result word.
// ----------------------------------------------------------------------------
module nlt_back
    import nlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_wr         i_wr,
    input  logic        i_q_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_busy,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int NB_W  = CNT_W + PIX_W;
    localparam int D_W   = (NB_W > SUM_W) ? NB_W : SUM_W;
    localparam int LM_W  = D_W + 8;
    localparam int LHS_W = 2 * LM_W;
    localparam int VAR_W = CNT_W + SQ_W;
    localparam int KK_W  = 2 * K_W - 1;
    localparam int RHS_W = KK_W + VAR_W;
    localparam int CMP_W = (RHS_W > LHS_W) ? RHS_W : LHS_W;
    localparam int BIT_W = $clog2(KK_W);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_PLACE, S_SCAN, S_DRAIN, S_MUL, S_DIFF, S_SER, S_DONE
    } t_state;

    logic [PIX_W-1:0] r_store [STORE_DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] rd_addr;

    t_state            r_state;
    t_job              r_job;
    logic [RAD_W-1:0]  r_up;
    logic [RAD_W-1:0]  r_left;
    logic [WIN_W-1:0]  r_hr;
    logic [WIN_W-1:0]  r_wc;
    logic [WIN_W-1:0]  r_dy;
    logic [WIN_W-1:0]  r_dx;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_row_start;
    logic              r_acc_en;
    logic [PIX_W-1:0]  r_center;
    logic [CNT_W-1:0]  r_n;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sq;
    logic [NB_W-1:0]   r_nb;
    logic [VAR_W-1:0]  r_ns;
    logic [VAR_W-1:0]  r_s2;
    logic [KK_W-1:0]   r_kk;
    logic              r_neg;
    logic              r_lnz;
    logic [LHS_W-1:0]  r_lhs;
    logic [RHS_W-1:0]  r_var_sh;
    logic [RHS_W-1:0]  r_rhs;
    logic [BIT_W-1:0]  r_bit;
    logic              r_ovalid;
    logic [23:0]       r_odata;
    logic              r_olast;

    logic [31:0]       dn_room;
    logic [31:0]       rt_room;
    logic [RAD_W-1:0]  up;
    logic [RAD_W-1:0]  down;
    logic [RAD_W-1:0]  left;
    logic [RAD_W-1:0]  right;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W:0]   start;
    logic [ADDR_W:0]   nxt_row;
    logic [ADDR_W-1:0] nxt_addr;
    logic              col_end;
    logic              scan_end;
    logic [K_W-1:0]    kmag;
    logic [VAR_W-1:0]  nb_x;
    logic [VAR_W-1:0]  s_x;
    logic [D_W-1:0]    dmag;
    logic [LM_W-1:0]   lmag;
    logic [CMP_W-1:0]  lhs_c;
    logic [CMP_W-1:0]  rhs_c;
    logic              black;

    // window extent around the job's pixel, clipped at the frame edges
    always_comb begin
        dn_room = 32'(i_cfg.height) - 32'd1 - 32'(r_job.row);
        rt_room = 32'(i_cfg.width) - 32'd1 - 32'(r_job.col);
        up      = (32'(r_job.row) > 32'(i_cfg.radius)) ? i_cfg.radius : RAD_W'(r_job.row);
        left    = (32'(r_job.col) > 32'(i_cfg.radius)) ? i_cfg.radius : RAD_W'(r_job.col);
        down    = (dn_room > 32'(i_cfg.radius)) ? i_cfg.radius : RAD_W'(dn_room);
        right   = (rt_room > 32'(i_cfg.radius)) ? i_cfg.radius : RAD_W'(rt_room);
    end

    // first tap address: pixel address minus up rows and left columns
    always_comb begin
        off   = ADDR_W'(r_up * i_cfg.width) + ADDR_W'(r_left);
        start = (r_job.addr >= off) ? {1'b0, r_job.addr} - {1'b0, off} :
                {1'b0, r_job.addr} + (ADDR_W+1)'(STORE_DEPTH) - {1'b0, off};
    end

    // tap walk
    always_comb begin
        col_end  = r_dx == r_wc - 1'b1;
        scan_end = col_end && (r_dy == r_hr - 1'b1);
        nxt_row  = {1'b0, r_row_start} + (ADDR_W+1)'(i_cfg.width);
        if (32'(nxt_row) >= STORE_DEPTH) begin
            nxt_row = nxt_row - (ADDR_W+1)'(STORE_DEPTH);
        end
        nxt_addr = (32'(r_addr) == STORE_DEPTH - 1) ? '0 : r_addr + 1'b1;
        rd_addr  = (r_state == S_SETUP) ? r_job.addr : r_addr;
    end

    // threshold arithmetic
    always_comb begin
        kmag  = i_cfg.k[K_W-1] ? K_W'(-i_cfg.k) : K_W'(i_cfg.k);
        nb_x  = VAR_W'(r_nb);
        s_x   = VAR_W'(r_sum);
        dmag  = (nb_x < s_x) ? D_W'(s_x - nb_x) : D_W'(nb_x - s_x);
        lmag  = {dmag, 8'b0};
        lhs_c = CMP_W'(r_lhs);
        rhs_c = CMP_W'(r_rhs);
        if (!i_cfg.k[K_W-1]) begin
            black = r_neg ? (r_lnz || r_rhs != '0) : (lhs_c < rhs_c);
        end else begin
            black = r_neg && (lhs_c > rhs_c);
        end
    end

    assign o_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_busy     = r_state != S_IDLE;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    // line store
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[rd_addr];
    end

    // sequencer, datapath and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= r_state == S_SCAN;
            if (r_acc_en) begin
                r_sum <= r_sum + SUM_W'(r_rd_data);
                r_sq  <= r_sq + SQ_W'(r_rd_data * r_rd_data);
            end
            // a taken word empties the output unless the next one replaces it
            if (r_ovalid && i_m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job   <= i_job;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_up    <= up;
                    r_left  <= left;
                    r_hr    <= WIN_W'(up) + WIN_W'(down) + 1'b1;
                    r_wc    <= WIN_W'(left) + WIN_W'(right) + 1'b1;
                    r_state <= S_PLACE;
                end
                S_PLACE: begin
                    r_center    <= r_rd_data;
                    r_n         <= CNT_W'(r_hr * r_wc);
                    r_addr      <= start[ADDR_W-1:0];
                    r_row_start <= start[ADDR_W-1:0];
                    r_dx        <= '0;
                    r_dy        <= '0;
                    r_sum       <= '0;
                    r_sq        <= '0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (col_end) begin
                        r_dx        <= '0;
                        r_dy        <= r_dy + 1'b1;
                        r_row_start <= nxt_row[ADDR_W-1:0];
                        r_addr      <= nxt_row[ADDR_W-1:0];
                    end else begin
                        r_dx   <= r_dx + 1'b1;
                        r_addr <= nxt_addr;
                    end
                    if (scan_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_nb    <= NB_W'(r_n * r_center);
                    r_ns    <= VAR_W'(r_n * r_sq);
                    r_s2    <= VAR_W'(r_sum * r_sum);
                    r_kk    <= KK_W'(kmag * kmag);
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_neg    <= nb_x < s_x;
                    r_lnz    <= dmag != '0;
                    r_lhs    <= LHS_W'(lmag * lmag);
                    r_var_sh <= (r_ns > r_s2) ? RHS_W'(r_ns - r_s2) : '0;
                    r_rhs    <= '0;
                    r_bit    <= '0;
                    r_state  <= S_SER;
                end
                S_SER: begin
                    // shift-add of k squared times the variance term
                    if (r_kk[0]) begin
                        r_rhs <= r_rhs + r_var_sh;
                    end
                    r_kk     <= r_kk >> 1;
                    r_var_sh <= r_var_sh << 1;
                    r_bit    <= r_bit + 1'b1;
                    if (32'(r_bit) == KK_W - 1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {1'b0, COORD_W'(r_job.col), COORD_W'(r_job.row), !black};
                        r_olast  <= r_job.last;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/niblack_local_threshold_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// niblack_local_threshold_top
// Niblack binarization of a raster grayscale stream over a clipped square
// window, with exact windowed sums and a division-free threshold test.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser / tlast
//  s (in)    in   [7:0] pixel                              tuser: kind
//  m (out)   out  [0] is_white [11:1] out_row [22:12] col  tlast: frame_end
//  cfg       in   we, idx (radius, k_q8, width, height), data
//
//  a word that causes no result does not hold off the input; one that causes a
//  result holds it off while its clipped window (up to 6561 pixels) is summed
//  through the single read port of the line store, one tap a cycle, and tested.
//  reset is synchronous, active low; the input is held off in the cycle after
//  reset and after each register write; the line store is not cleared.
//  the input stalls while a window is summed; a result held in the output
//  register blocks it only once the next window is done.
// ----------------------------------------------------------------------------
module niblack_local_threshold_top
    import nlt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] pixel
    input  logic             i_s_tuser,   // [0] kind
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [23:0]      o_m_tdata,   // [0] is_white, [11:1] out_row, [22:12] out_column
    output logic             o_m_tlast
);

    logic push;
    logic pop;
    logic q_valid;
    logic q_empty;
    logic back_busy;
    t_job job_in;
    t_job job_out;
    t_wr  wr;
    t_cfg cfg;

    nlt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_s_tready  (o_s_tready),
        .i_q_empty   (q_empty),
        .i_back_busy (back_busy),
        .o_push      (push),
        .o_job       (job_in),
        .o_wr        (wr),
        .o_cfg       (cfg)
    );

    nlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    nlt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_wr       (wr),
        .i_q_valid  (q_valid),
        .i_job      (job_out),
        .o_pop      (pop),
        .o_busy     (back_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
